### sv/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

   localparam logic [14:0] STEP_ONE   = 15'd3728;
   localparam logic [14:0] STEP_TWO   = 15'd7456;
   localparam logic [14:0] STEP_THREE = 15'd11185;
   localparam logic [14:0] STEP_FOUR  = 15'd14914;
   localparam logic [14:0] STEP_FIVE  = 15'd18640;

   localparam logic [11:0] CHANNEL_PAGE  = 12'h400;
   localparam logic [13:0] SAMPLE_PAGE   = 14'h1004;
   localparam logic [15:0] STATUS_ADDR   = 16'h4015;
   localparam logic [15:0] FRAME_ADDR    = 16'h4017;

   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_LOAD    = 2'd3;
   localparam logic [1:0] CH_TRIANGLE = 2'd2;

   localparam logic [2:0] DELAY_ODD  = 3'd4;
   localparam logic [2:0] DELAY_EVEN = 3'd3;

   typedef struct packed {
      logic [7:0] read_data;
      logic       claimed;
      logic       irq_request;
      logic       frame_clock;
      logic       half_clock;
   } result_type;

   function automatic logic [7:0] load_length(input logic [4:0] index);
      logic [7:0] value;
      case (index)
         5'd0:  value = 8'd10;
         5'd1:  value = 8'd254;
         5'd2:  value = 8'd20;
         5'd3:  value = 8'd2;
         5'd4:  value = 8'd40;
         5'd5:  value = 8'd4;
         5'd6:  value = 8'd80;
         5'd7:  value = 8'd6;
         5'd8:  value = 8'd160;
         5'd9:  value = 8'd8;
         5'd10: value = 8'd60;
         5'd11: value = 8'd10;
         5'd12: value = 8'd14;
         5'd13: value = 8'd12;
         5'd14: value = 8'd26;
         5'd15: value = 8'd14;
         5'd16: value = 8'd12;
         5'd17: value = 8'd16;
         5'd18: value = 8'd24;
         5'd19: value = 8'd18;
         5'd20: value = 8'd48;
         5'd21: value = 8'd20;
         5'd22: value = 8'd96;
         5'd23: value = 8'd22;
         5'd24: value = 8'd192;
         5'd25: value = 8'd24;
         5'd26: value = 8'd72;
         5'd27: value = 8'd26;
         5'd28: value = 8'd16;
         5'd29: value = 8'd28;
         5'd30: value = 8'd32;
         default: value = 8'd30;
      endcase
      return value;
   endfunction

endpackage

### sv/apu_frame_sequencer_length_counters_top.sv
`timescale 1ns / 1ps
// Frame sequencer and four length counters of a console audio unit.
// Request channel (req_valid / req_stall): one beat per item, req_command
// selects a cpu-cycle tick, a bus write or a bus read; req_bus_address and
// req_write_data carry the access.
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// in order: status byte, claim flag, interrupt request and frame clocks.
// A request beat lands in an input register, is worked combinationally against
// the sequencer and counter state, and its response beat is then captured in
// the output register, whose valid bit drives rsp_valid.
// Throughput is one beat per cycle while rsp_stall is low.
// When rsp_stall is high the output register holds its beat; the input
// register still takes one more beat, then req_stall rises until the
// output frees up.
// Synchronous reset clears the sequencer, the mode and interrupt bits and
// all length counters, halts and enables, and empties both registers.
module apu_frame_sequencer_length_counters_top import afs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_claimed,
   output logic        rsp_irq_request,
   output logic        rsp_frame_clock,
   output logic        rsp_half_clock
);

   logic        in_valid_ff;
   logic [1:0]  command_ff;
   logic [15:0] bus_address_ff;
   logic [7:0]  write_data_ff;
   logic        out_valid_ff;
   result_type  result_ff;
   result_type  result_in;
   logic        advance;
   logic        accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   afs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .command     (command_ff),
      .bus_address (bus_address_ff),
      .write_data  (write_data_ff),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         command_ff     <= req_command;
         bus_address_ff <= req_bus_address;
         write_data_ff  <= req_write_data;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = result_ff.read_data;
   assign rsp_claimed     = result_ff.claimed;
   assign rsp_irq_request = result_ff.irq_request;
   assign rsp_frame_clock = result_ff.frame_clock;
   assign rsp_half_clock  = result_ff.half_clock;

   a_half_is_frame: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.half_clock |-> result_ff.frame_clock)
      else $error("half clock without frame clock");

   a_irq_on_half: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.irq_request |-> result_ff.half_clock)
      else $error("interrupt request off the half clock step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !advance)
      else $error("stalled response beat overwritten");

endmodule

### sv/afs_engine.sv
`timescale 1ns / 1ps

module afs_engine import afs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [1:0]  command,
   input  logic [15:0] bus_address,
   input  logic [7:0]  write_data,
   output result_type  result
);

   logic [14:0]     frame_cycle_ff, frame_cycle_in;
   logic            odd_phase_ff, odd_phase_in;
   logic            five_step_mode_ff, five_step_mode_in;
   logic            irq_inhibit_ff, irq_inhibit_in;
   logic            frame_irq_flag_ff, frame_irq_flag_in;
   logic [2:0]      mode_change_delay_ff, mode_change_delay_in;
   logic [3:0][7:0] length_count_ff, length_count_in;
   logic [3:0]      length_halt_ff, length_halt_in;
   logic [3:0]      length_enable_ff, length_enable_in;
   logic            sample_enable_ff, sample_enable_in;

   always_comb begin
      logic [14:0] fc;
      logic        quarter;
      logic        half;
      logic        irq;
      logic        wrap;
      logic [1:0]  ch;
      logic [3:0]  nonzero;

      frame_cycle_in       = frame_cycle_ff;
      odd_phase_in         = odd_phase_ff;
      five_step_mode_in    = five_step_mode_ff;
      irq_inhibit_in       = irq_inhibit_ff;
      frame_irq_flag_in    = frame_irq_flag_ff;
      mode_change_delay_in = mode_change_delay_ff;
      length_count_in      = length_count_ff;
      length_halt_in       = length_halt_ff;
      length_enable_in     = length_enable_ff;
      sample_enable_in     = sample_enable_ff;
      result               = '0;
      fc      = frame_cycle_ff;
      quarter = 1'b0;
      half    = 1'b0;
      irq     = 1'b0;
      wrap    = 1'b0;
      ch      = bus_address[3:2];
      for (int k = 0; k < 4; k++) begin
         nonzero[k] = (length_count_ff[k] != 8'd0);
      end

      case (command)
         CMD_TICK: begin
            if (!five_step_mode_ff && frame_cycle_ff == STEP_FOUR) begin
               frame_irq_flag_in = !irq_inhibit_ff;
            end
            if (odd_phase_ff) begin
               wrap = five_step_mode_ff ? (frame_cycle_ff > STEP_FIVE)
                                        : (frame_cycle_ff > STEP_FOUR);
               if (wrap) begin
                  fc = '0;
               end
               if (fc == STEP_TWO || fc == STEP_FIVE) begin
                  half = 1'b1;
               end else if (fc == STEP_ONE || fc == STEP_THREE) begin
                  quarter = 1'b1;
               end else if (fc == STEP_FOUR && !five_step_mode_ff) begin
                  half = 1'b1;
                  irq  = frame_irq_flag_in;
               end
               frame_cycle_in = fc + 15'd1;
            end
            if (mode_change_delay_ff != 3'd0) begin
               mode_change_delay_in = mode_change_delay_ff - 3'd1;
               if (mode_change_delay_ff == 3'd1) begin
                  half           = half | five_step_mode_ff;
                  frame_cycle_in = '0;
               end
            end
            if (half) begin
               for (int k = 0; k < 4; k++) begin
                  if (nonzero[k] && !length_halt_ff[k]) begin
                     length_count_in[k] = length_count_ff[k] - 8'd1;
                  end
               end
            end
            odd_phase_in       = !odd_phase_ff;
            result.irq_request = irq;
            result.frame_clock = quarter | half;
            result.half_clock  = half;
         end
         CMD_WRITE: begin
            if (bus_address[15:4] == CHANNEL_PAGE) begin
               result.claimed = 1'b1;
               if (bus_address[1:0] == REG_CONTROL) begin
                  length_halt_in[ch] = (ch == CH_TRIANGLE) ? write_data[7] : write_data[5];
               end else if (bus_address[1:0] == REG_LOAD && length_enable_ff[ch]) begin
                  length_count_in[ch] = load_length(write_data[7:3]);
               end
            end else if (bus_address[15:2] == SAMPLE_PAGE) begin
               result.claimed = 1'b1;
            end else if (bus_address == STATUS_ADDR) begin
               result.claimed   = 1'b1;
               length_enable_in = write_data[3:0];
               for (int k = 0; k < 4; k++) begin
                  if (!write_data[k]) begin
                     length_count_in[k] = 8'd0;
                  end
               end
               sample_enable_in = write_data[4];
            end else if (bus_address == FRAME_ADDR) begin
               result.claimed    = 1'b1;
               five_step_mode_in = write_data[7];
               irq_inhibit_in    = write_data[6];
               if (write_data[6]) begin
                  frame_irq_flag_in = 1'b0;
               end
               mode_change_delay_in = odd_phase_ff ? DELAY_ODD : DELAY_EVEN;
            end
         end
         CMD_READ: begin
            if (bus_address == STATUS_ADDR) begin
               result.claimed   = 1'b1;
               result.read_data = {1'b0, frame_irq_flag_ff, 1'b0, sample_enable_ff, nonzero};
               frame_irq_flag_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cycle_ff       <= '0;
         odd_phase_ff         <= 1'b0;
         five_step_mode_ff    <= 1'b0;
         irq_inhibit_ff       <= 1'b0;
         frame_irq_flag_ff    <= 1'b0;
         mode_change_delay_ff <= '0;
         length_count_ff      <= '0;
         length_halt_ff       <= '0;
         length_enable_ff     <= '0;
         sample_enable_ff     <= 1'b0;
      end else if (fire) begin
         frame_cycle_ff       <= frame_cycle_in;
         odd_phase_ff         <= odd_phase_in;
         five_step_mode_ff    <= five_step_mode_in;
         irq_inhibit_ff       <= irq_inhibit_in;
         frame_irq_flag_ff    <= frame_irq_flag_in;
         mode_change_delay_ff <= mode_change_delay_in;
         length_count_ff      <= length_count_in;
         length_halt_ff       <= length_halt_in;
         length_enable_ff     <= length_enable_in;
         sample_enable_ff     <= sample_enable_in;
      end
   end

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      mode_change_delay_ff <= DELAY_ODD)
      else $error("mode change delay out of range");

   a_cycle_range: assert property (@(posedge clock) disable iff (reset)
      frame_cycle_ff <= STEP_FIVE + 15'd1)
      else $error("frame cycle ran past its wrap point");

   a_read_clears_flag: assert property (@(posedge clock) disable iff (reset)
      fire && command == CMD_READ && bus_address == STATUS_ADDR |=> !frame_irq_flag_ff)
      else $error("status read left the frame interrupt flag set");

   a_disabled_empty: assert property (@(posedge clock) disable iff (reset)
      fire && command == CMD_WRITE && bus_address == STATUS_ADDR && !write_data[0]
      |=> length_count_ff[0] == 8'd0)
      else $error("disabled length counter kept a count");

endmodule
